/* rtl/hpp_pkg.sv */
// shared types, codes and token match functions for the http request head parser
// used by hpp_parse_core, the top level and the checker; depends on nothing
package hpp_pkg;

    localparam int TOKEN_BUF_BYTES  = 8;
    localparam int BODY_COUNT_WIDTH = 32;
    localparam int BODY_LIMIT_WIDTH = 32;
    localparam int TOK_IDX_W        = $clog2(TOKEN_BUF_BYTES);
    localparam int TOK_LEN_W        = 4;
    localparam int BODY_CMP_W       = (BODY_COUNT_WIDTH > BODY_LIMIT_WIDTH) ?
                                      BODY_COUNT_WIDTH : BODY_LIMIT_WIDTH;

    localparam logic [BODY_LIMIT_WIDTH-1:0] MAX_BODY_RESET = 32'd1048576;

    localparam logic [TOK_LEN_W-1:0] TOK_LEN_SAT        = 4'd15;
    localparam logic [TOK_LEN_W-1:0] METHOD_LEN_LIMIT   = 4'd7;
    localparam logic [TOK_LEN_W-1:0] VERSION_LEN_LIMIT  = 4'd8;
    localparam logic [TOK_LEN_W-1:0] VERSION_LEN        = 4'd8;

    // characters
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_COLON = 8'h3a;
    localparam logic [7:0] CH_SLASH = 8'h2f;
    localparam logic [7:0] CH_CTL_MAX = 8'd31;
    localparam logic [7:0] CH_DEL   = 8'd127;

    // byte kind codes
    localparam logic [2:0] KIND_DELIM   = 3'd0;
    localparam logic [2:0] KIND_METHOD  = 3'd1;
    localparam logic [2:0] KIND_URI     = 3'd2;
    localparam logic [2:0] KIND_VERSION = 3'd3;
    localparam logic [2:0] KIND_KEY     = 3'd4;
    localparam logic [2:0] KIND_VALUE   = 3'd5;
    localparam logic [2:0] KIND_PAYLOAD = 3'd6;

    // status codes
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_BAD       = 2'd1;
    localparam logic [1:0] STATUS_TOO_LARGE = 2'd2;
    localparam logic [1:0] STATUS_DROPPED   = 2'd3;

    // method codes
    localparam logic [2:0] METHOD_NONE    = 3'd0;
    localparam logic [2:0] METHOD_GET     = 3'd1;
    localparam logic [2:0] METHOD_PUT     = 3'd2;
    localparam logic [2:0] METHOD_POST    = 3'd3;
    localparam logic [2:0] METHOD_PATCH   = 3'd4;
    localparam logic [2:0] METHOD_DELETE  = 3'd5;
    localparam logic [2:0] METHOD_OPTIONS = 3'd6;

    // version codes
    localparam logic [1:0] VERSION_NONE = 2'd0;
    localparam logic [1:0] VERSION_1_0  = 2'd1;
    localparam logic [1:0] VERSION_1_1  = 2'd2;

    typedef enum logic [3:0] {
        STAGE_METHOD  = 4'd0,
        STAGE_URI     = 4'd1,
        STAGE_PROTO   = 4'd2,
        STAGE_NL1     = 4'd3,
        STAGE_KEY     = 4'd4,
        STAGE_SPACE   = 4'd5,
        STAGE_VALUE   = 4'd6,
        STAGE_NL2     = 4'd7,
        STAGE_NL3     = 4'd8,
        STAGE_PAYLOAD = 4'd9
    } stage_t;

    typedef logic [TOKEN_BUF_BYTES-1:0][7:0] tok_buf_t;

    typedef struct packed {
        logic [7:0] byte_out;
        logic [2:0] byte_kind;
        logic       field_end;
        logic       head_done;
        logic [1:0] status;
        logic [2:0] method_code;
        logic [1:0] version_code;
    } result_t;

    function automatic logic is_ctl(input logic [7:0] c);
        return c inside {[8'd0:CH_CTL_MAX], CH_DEL};
    endfunction

    function automatic logic [2:0] match_method(input tok_buf_t buf_in,
                                                input logic [TOK_LEN_W-1:0] len);
        logic [2:0] code;
        code = METHOD_NONE;
        case (len)
            4'd3: begin
                if ({buf_in[0], buf_in[1], buf_in[2]} == "GET") code = METHOD_GET;
                else if ({buf_in[0], buf_in[1], buf_in[2]} == "PUT") code = METHOD_PUT;
            end
            4'd4: begin
                if ({buf_in[0], buf_in[1], buf_in[2], buf_in[3]} == "POST")
                    code = METHOD_POST;
            end
            4'd5: begin
                if ({buf_in[0], buf_in[1], buf_in[2], buf_in[3], buf_in[4]} == "PATCH")
                    code = METHOD_PATCH;
            end
            4'd6: begin
                if ({buf_in[0], buf_in[1], buf_in[2], buf_in[3], buf_in[4],
                     buf_in[5]} == "DELETE")
                    code = METHOD_DELETE;
            end
            4'd7: begin
                if ({buf_in[0], buf_in[1], buf_in[2], buf_in[3], buf_in[4],
                     buf_in[5], buf_in[6]} == "OPTIONS")
                    code = METHOD_OPTIONS;
            end
            default: code = METHOD_NONE;
        endcase
        return code;
    endfunction

    function automatic logic [1:0] match_version(input tok_buf_t buf_in,
                                                 input logic [TOK_LEN_W-1:0] len);
        logic [1:0] code;
        code = VERSION_NONE;
        if (len == VERSION_LEN &&
            {buf_in[0], buf_in[1], buf_in[2], buf_in[3], buf_in[4], buf_in[5],
             buf_in[6]} == "HTTP/1.") begin
            if (buf_in[7] == "1") code = VERSION_1_1;
            else if (buf_in[7] == "0") code = VERSION_1_0;
        end
        return code;
    endfunction

endpackage

/* rtl/hpp_parse_core.sv */
// per-byte stage machine of the request head parser: request state registers,
// token buffer and the combinational step; depends on hpp_pkg
module hpp_parse_core (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  step_en,
    input  logic [7:0]                            data_byte,
    input  logic                                  start_request,
    input  logic [hpp_pkg::BODY_LIMIT_WIDTH-1:0]  max_body_size,
    output hpp_pkg::result_t                      result
);

    hpp_pkg::stage_t                         stage_reg, stage_next, stage_eff;
    hpp_pkg::tok_buf_t                       tok_buf_reg;
    logic [hpp_pkg::TOK_LEN_W-1:0]           tok_len_reg, tok_len_next, tok_len_eff;
    logic                                    nonempty_reg, nonempty_next, nonempty_eff;
    logic [2:0]                              method_reg, method_next, method_eff;
    logic [1:0]                              version_reg, version_next, version_eff;
    logic [hpp_pkg::BODY_COUNT_WIDTH-1:0]    count_reg, count_next, count_eff;
    logic                                    error_reg, error_next, error_eff;

    logic [2:0] kind;
    logic       fend;
    logic       hdone;
    logic [1:0] status;
    logic       ok;
    logic       do_push, clr_len, clr_ne, set_ne, set_buf0;
    logic       ld_method, ld_version, inc_count;
    logic [2:0] method_match;
    logic [1:0] version_match;
    logic       body_full;
    logic       body_at_limit;
    logic       push_in_range;

    // a start clears the request state before this byte is parsed
    always_comb begin
        if (start_request) begin
            stage_eff    = hpp_pkg::STAGE_METHOD;
            tok_len_eff  = '0;
            nonempty_eff = 1'b0;
            method_eff   = hpp_pkg::METHOD_NONE;
            version_eff  = hpp_pkg::VERSION_NONE;
            count_eff    = '0;
            error_eff    = 1'b0;
        end else begin
            stage_eff    = stage_reg;
            tok_len_eff  = tok_len_reg;
            nonempty_eff = nonempty_reg;
            method_eff   = method_reg;
            version_eff  = version_reg;
            count_eff    = count_reg;
            error_eff    = error_reg;
        end
    end

    assign method_match  = hpp_pkg::match_method(tok_buf_reg, tok_len_eff);
    assign version_match = hpp_pkg::match_version(tok_buf_reg, tok_len_eff);
    assign body_full     = &count_eff;
    assign body_at_limit = hpp_pkg::BODY_CMP_W'(count_eff) >=
                           hpp_pkg::BODY_CMP_W'(max_body_size);
    assign push_in_range = {1'b0, tok_len_eff} <
                           (hpp_pkg::TOK_LEN_W + 1)'(hpp_pkg::TOKEN_BUF_BYTES);

    // result fields and state update requests
    always_comb begin
        kind       = hpp_pkg::KIND_DELIM;
        fend       = 1'b0;
        hdone      = 1'b0;
        status     = hpp_pkg::STATUS_OK;
        do_push    = 1'b0;
        clr_len    = 1'b0;
        clr_ne     = 1'b0;
        set_ne     = 1'b0;
        set_buf0   = 1'b0;
        ld_method  = 1'b0;
        ld_version = 1'b0;
        inc_count  = 1'b0;
        if (error_eff) begin
            status = hpp_pkg::STATUS_DROPPED;
        end else begin
            case (stage_eff)
                hpp_pkg::STAGE_METHOD: begin
                    if (data_byte == hpp_pkg::CH_SP) begin
                        if (method_match == hpp_pkg::METHOD_NONE) begin
                            status = hpp_pkg::STATUS_BAD;
                        end else begin
                            ld_method = 1'b1;
                            fend      = 1'b1;
                            clr_len   = 1'b1;
                            clr_ne    = 1'b1;
                        end
                    end else if (tok_len_eff > hpp_pkg::METHOD_LEN_LIMIT) begin
                        status = hpp_pkg::STATUS_BAD;
                    end else begin
                        do_push = 1'b1;
                        kind    = hpp_pkg::KIND_METHOD;
                    end
                end
                hpp_pkg::STAGE_URI: begin
                    if (data_byte == hpp_pkg::CH_SP) begin
                        if (!nonempty_eff || tok_buf_reg[0] != hpp_pkg::CH_SLASH) begin
                            status = hpp_pkg::STATUS_BAD;
                        end else begin
                            fend    = 1'b1;
                            clr_len = 1'b1;
                            clr_ne  = 1'b1;
                        end
                    end else if (hpp_pkg::is_ctl(data_byte)) begin
                        status = hpp_pkg::STATUS_BAD;
                    end else begin
                        // only the first uri byte is kept, for the leading slash check
                        set_buf0 = !nonempty_eff;
                        set_ne   = 1'b1;
                        kind     = hpp_pkg::KIND_URI;
                    end
                end
                hpp_pkg::STAGE_PROTO: begin
                    if (data_byte == hpp_pkg::CH_CR) begin
                        if (version_match == hpp_pkg::VERSION_NONE) begin
                            status = hpp_pkg::STATUS_BAD;
                        end else begin
                            ld_version = 1'b1;
                            fend       = 1'b1;
                            clr_len    = 1'b1;
                        end
                    end else if (tok_len_eff > hpp_pkg::VERSION_LEN_LIMIT) begin
                        status = hpp_pkg::STATUS_BAD;
                    end else begin
                        do_push = 1'b1;
                        kind    = hpp_pkg::KIND_VERSION;
                    end
                end
                hpp_pkg::STAGE_NL1, hpp_pkg::STAGE_NL2: begin
                    if (data_byte == hpp_pkg::CH_LF) clr_ne = 1'b1;
                    else status = hpp_pkg::STATUS_BAD;
                end
                hpp_pkg::STAGE_KEY: begin
                    if (data_byte == hpp_pkg::CH_CR) begin
                        // cr at line start is the blank line, after key bytes it is bad
                        if (nonempty_eff) status = hpp_pkg::STATUS_BAD;
                    end else if (data_byte == hpp_pkg::CH_COLON) begin
                        fend   = 1'b1;
                        clr_ne = 1'b1;
                    end else if (hpp_pkg::is_ctl(data_byte)) begin
                        status = hpp_pkg::STATUS_BAD;
                    end else begin
                        set_ne = 1'b1;
                        kind   = hpp_pkg::KIND_KEY;
                    end
                end
                hpp_pkg::STAGE_SPACE: begin
                    if (data_byte != hpp_pkg::CH_SP) status = hpp_pkg::STATUS_BAD;
                end
                hpp_pkg::STAGE_VALUE: begin
                    if (data_byte == hpp_pkg::CH_CR) begin
                        fend = 1'b1;
                    end else if (hpp_pkg::is_ctl(data_byte)) begin
                        status = hpp_pkg::STATUS_BAD;
                    end else begin
                        kind = hpp_pkg::KIND_VALUE;
                    end
                end
                hpp_pkg::STAGE_NL3: begin
                    if (data_byte == hpp_pkg::CH_LF) hdone = 1'b1;
                    else status = hpp_pkg::STATUS_BAD;
                end
                hpp_pkg::STAGE_PAYLOAD: begin
                    if (!(method_eff inside {hpp_pkg::METHOD_PUT, hpp_pkg::METHOD_POST,
                                             hpp_pkg::METHOD_PATCH})) begin
                        status = hpp_pkg::STATUS_BAD;
                    end else if (body_full || body_at_limit) begin
                        status = hpp_pkg::STATUS_TOO_LARGE;
                    end else begin
                        inc_count = 1'b1;
                        kind      = hpp_pkg::KIND_PAYLOAD;
                    end
                end
                default: status = hpp_pkg::STATUS_BAD;
            endcase
        end
    end

    assign ok = (status == hpp_pkg::STATUS_OK);

    // stage transitions; an erroneous or dropped byte leaves the stage alone
    always_comb begin
        stage_next = stage_eff;
        if (ok) begin
            case (stage_eff)
                hpp_pkg::STAGE_METHOD:
                    if (data_byte == hpp_pkg::CH_SP) stage_next = hpp_pkg::STAGE_URI;
                hpp_pkg::STAGE_URI:
                    if (data_byte == hpp_pkg::CH_SP) stage_next = hpp_pkg::STAGE_PROTO;
                hpp_pkg::STAGE_PROTO:
                    if (data_byte == hpp_pkg::CH_CR) stage_next = hpp_pkg::STAGE_NL1;
                hpp_pkg::STAGE_NL1, hpp_pkg::STAGE_NL2:
                    stage_next = hpp_pkg::STAGE_KEY;
                hpp_pkg::STAGE_KEY: begin
                    if (data_byte == hpp_pkg::CH_CR) stage_next = hpp_pkg::STAGE_NL3;
                    else if (data_byte == hpp_pkg::CH_COLON)
                        stage_next = hpp_pkg::STAGE_SPACE;
                end
                hpp_pkg::STAGE_SPACE:
                    stage_next = hpp_pkg::STAGE_VALUE;
                hpp_pkg::STAGE_VALUE:
                    if (data_byte == hpp_pkg::CH_CR) stage_next = hpp_pkg::STAGE_NL2;
                hpp_pkg::STAGE_NL3:
                    stage_next = hpp_pkg::STAGE_PAYLOAD;
                default: stage_next = stage_eff;
            endcase
        end
    end

    always_comb begin
        error_next = error_eff ||
                     status == hpp_pkg::STATUS_BAD || status == hpp_pkg::STATUS_TOO_LARGE;

        tok_len_next = tok_len_eff;
        if (ok && clr_len) tok_len_next = '0;
        else if (ok && do_push && tok_len_eff != hpp_pkg::TOK_LEN_SAT)
            tok_len_next = tok_len_eff + 1'b1;

        nonempty_next = nonempty_eff;
        if (ok && clr_ne) nonempty_next = 1'b0;
        else if (ok && set_ne) nonempty_next = 1'b1;

        method_next  = (ok && ld_method)  ? method_match  : method_eff;
        version_next = (ok && ld_version) ? version_match : version_eff;
        count_next   = (ok && inc_count)  ? count_eff + 1'b1 : count_eff;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_reg    <= hpp_pkg::STAGE_METHOD;
            tok_len_reg  <= '0;
            nonempty_reg <= 1'b0;
            method_reg   <= hpp_pkg::METHOD_NONE;
            version_reg  <= hpp_pkg::VERSION_NONE;
            count_reg    <= '0;
            error_reg    <= 1'b0;
        end else if (step_en) begin
            stage_reg    <= stage_next;
            tok_len_reg  <= tok_len_next;
            nonempty_reg <= nonempty_next;
            method_reg   <= method_next;
            version_reg  <= version_next;
            count_reg    <= count_next;
            error_reg    <= error_next;
        end
    end

    // token bytes past the buffer depth are counted but not stored
    always_ff @(posedge aclk) begin
        if (step_en && ok) begin
            if (do_push && push_in_range)
                tok_buf_reg[tok_len_eff[hpp_pkg::TOK_IDX_W-1:0]] <= data_byte;
            else if (set_buf0)
                tok_buf_reg[0] <= data_byte;
        end
    end

    assign result.byte_out     = data_byte;
    assign result.byte_kind    = kind;
    assign result.field_end    = fend;
    assign result.head_done    = hdone;
    assign result.status       = status;
    assign result.method_code  = method_next;
    assign result.version_code = version_next;

endmodule

/* rtl/http_request_head_parser_unit.sv */
// each accepted byte waits in the input register, then its result is held in the
// result register on m_valid; throughput: one byte per cycle while m_ready stays
// high; the hpp_parse_core stage machine closes its loop between the two registers
// reset: aresetn (synchronous, active low) empties both registers, returns the
// parser to the method stage and sets max_body_size to 1048576
module http_request_head_parser_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_start_request,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_byte_out,
    output logic [2:0]  m_byte_kind,
    output logic        m_field_end,
    output logic        m_head_done,
    output logic [1:0]  m_status,
    output logic [2:0]  m_method_code,
    output logic [1:0]  m_version_code,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata
);

    logic                                  in_valid_reg, in_valid_next;
    logic [7:0]                            in_byte_reg;
    logic                                  in_start_reg;
    logic                                  out_valid_reg, out_valid_next;
    hpp_pkg::result_t                      out_reg;
    hpp_pkg::result_t                      step_result;
    logic [hpp_pkg::BODY_LIMIT_WIDTH-1:0]  max_body_reg;
    logic                                  advance;
    logic                                  s_take;

    // the input item moves on when the result register is free or being drained
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign s_take  = s_valid && s_ready;

    assign in_valid_next  = s_take || (in_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            max_body_reg  <= hpp_pkg::MAX_BODY_RESET;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we) max_body_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_take) begin
            in_byte_reg  <= s_data_byte;
            in_start_reg <= s_start_request;
        end
        if (advance) out_reg <= step_result;
    end

    hpp_parse_core u_core (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .step_en       (advance),
        .data_byte     (in_byte_reg),
        .start_request (in_start_reg),
        .max_body_size (max_body_reg),
        .result        (step_result)
    );

    assign m_valid        = out_valid_reg;
    assign m_byte_out     = out_reg.byte_out;
    assign m_byte_kind    = out_reg.byte_kind;
    assign m_field_end    = out_reg.field_end;
    assign m_head_done    = out_reg.head_done;
    assign m_status       = out_reg.status;
    assign m_method_code  = out_reg.method_code;
    assign m_version_code = out_reg.version_code;

endmodule

/* rtl/hpp_checker.sv */
// port-level checks for http_request_head_parser_unit, attached by bind
// depends on hpp_pkg for the result codes
module hpp_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_byte_out,
    input logic [2:0] m_byte_kind,
    input logic       m_field_end,
    input logic       m_head_done,
    input logic [1:0] m_status,
    input logic [2:0] m_method_code
);

    // nothing comes out of a block that was just reset
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // a stalled result stays put
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_byte_out) && $stable(m_status)
                                && $stable(m_byte_kind))
        else $error("stalled result changed");

    // a rejected or dropped byte carries no tags
    a_err_untagged: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != hpp_pkg::STATUS_OK |->
            m_byte_kind == hpp_pkg::KIND_DELIM && !m_field_end && !m_head_done)
        else $error("errored byte carries a tag");

    // the head ends only on an accepted line feed
    a_head_done_lf: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_head_done |->
            m_byte_out == hpp_pkg::CH_LF && m_status == hpp_pkg::STATUS_OK)
        else $error("head done on a byte other than line feed");

    // payload only passes for methods that carry a body
    a_payload_method: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_byte_kind == hpp_pkg::KIND_PAYLOAD |->
            m_method_code == hpp_pkg::METHOD_PUT || m_method_code == hpp_pkg::METHOD_POST
            || m_method_code == hpp_pkg::METHOD_PATCH)
        else $error("payload byte for a method without body");

endmodule

bind http_request_head_parser_unit hpp_checker u_hpp_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_byte_out    (m_byte_out),
    .m_byte_kind   (m_byte_kind),
    .m_field_end   (m_field_end),
    .m_head_done   (m_head_done),
    .m_status      (m_status),
    .m_method_code (m_method_code)
);

/* tb/sv/http_head_checker.sv */
// checker for the http request head parser: follows both handshakes, predicts each tag
// result on its own copy of the parse state and compares it; depends on hpp_pkg
module http_head_checker
    import hpp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_start_request,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [7:0]  m_byte_out,
    input  logic [2:0]  m_byte_kind,
    input  logic        m_field_end,
    input  logic        m_head_done,
    input  logic [1:0]  m_status,
    input  logic [2:0]  m_method_code,
    input  logic [1:0]  m_version_code,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,
    output int          fail_count,
    output int          pending
);

    stage_t                        cur_stage;
    logic [7:0]                    tok_bytes [TOKEN_BUF_BYTES];
    logic [TOK_LEN_W-1:0]          tok_len;
    logic                          field_seen;
    logic [2:0]                    method_now;
    logic [1:0]                    version_now;
    logic [BODY_COUNT_WIDTH-1:0]   body_bytes;
    logic                          sticky_err;
    logic [BODY_LIMIT_WIDTH-1:0]   body_limit;

    result_t predicted_tags[$];
    result_t want;

    function automatic void clear_request();
        cur_stage = STAGE_METHOD;
        foreach (tok_bytes[i]) tok_bytes[i] = 8'd0;
        tok_len = '0;
        field_seen = 1'b0;
        method_now = METHOD_NONE;
        version_now = VERSION_NONE;
        body_bytes = '0;
        sticky_err = 1'b0;
    endfunction

    function automatic logic ctl_byte(input logic [7:0] c);
        return (c <= CH_CTL_MAX) || (c == CH_DEL);
    endfunction

    function automatic void store_tok(input logic [7:0] c);
        if (tok_len < TOKEN_BUF_BYTES) tok_bytes[tok_len[TOK_IDX_W-1:0]] = c;
        if (tok_len < TOK_LEN_SAT) tok_len = tok_len + 1'b1;
    endfunction

    function automatic logic tok_starts_with(input string s);
        for (int i = 0; i < s.len(); i++) begin
            if (i >= TOKEN_BUF_BYTES || tok_bytes[i] != s[i]) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic logic tok_is(input string s);
        return (tok_len == s.len()) && tok_starts_with(s);
    endfunction

    function automatic logic [2:0] method_of_tok();
        if (tok_is("GET")) return METHOD_GET;
        if (tok_is("PUT")) return METHOD_PUT;
        if (tok_is("POST")) return METHOD_POST;
        if (tok_is("PATCH")) return METHOD_PATCH;
        if (tok_is("DELETE")) return METHOD_DELETE;
        if (tok_is("OPTIONS")) return METHOD_OPTIONS;
        return METHOD_NONE;
    endfunction

    function automatic logic [1:0] version_of_tok();
        if (tok_len == VERSION_LEN && tok_starts_with("HTTP/1.")) begin
            if (tok_bytes[7] == "1") return VERSION_1_1;
            if (tok_bytes[7] == "0") return VERSION_1_0;
        end
        return VERSION_NONE;
    endfunction

    // advances the parse state by one byte and returns its tag
    function automatic result_t tag_byte(input logic [7:0] c, input logic restart);
        result_t    r;
        logic [1:0] st;
        logic [2:0] kind;
        logic       fend;
        logic       hdone;
        logic [2:0] m;
        logic [1:0] v;
        if (restart) clear_request();
        st = STATUS_OK;
        kind = KIND_DELIM;
        fend = 1'b0;
        hdone = 1'b0;
        if (sticky_err) begin
            st = STATUS_DROPPED;
        end else begin
            case (cur_stage)
                STAGE_METHOD: begin
                    if (c == CH_SP) begin
                        m = method_of_tok();
                        if (m == METHOD_NONE) begin
                            st = STATUS_BAD;
                        end else begin
                            method_now = m;
                            fend = 1'b1;
                            cur_stage = STAGE_URI;
                            tok_len = '0;
                            field_seen = 1'b0;
                        end
                    end else if (tok_len > METHOD_LEN_LIMIT) begin
                        st = STATUS_BAD;
                    end else begin
                        store_tok(c);
                        kind = KIND_METHOD;
                    end
                end
                STAGE_URI: begin
                    if (c == CH_SP) begin
                        if (!field_seen || tok_bytes[0] != CH_SLASH) begin
                            st = STATUS_BAD;
                        end else begin
                            fend = 1'b1;
                            cur_stage = STAGE_PROTO;
                            tok_len = '0;
                            field_seen = 1'b0;
                        end
                    end else if (ctl_byte(c)) begin
                        st = STATUS_BAD;
                    end else begin
                        // only the first uri byte is kept, for the slash check
                        if (!field_seen) tok_bytes[0] = c;
                        field_seen = 1'b1;
                        kind = KIND_URI;
                    end
                end
                STAGE_PROTO: begin
                    if (c == CH_CR) begin
                        v = version_of_tok();
                        if (v == VERSION_NONE) begin
                            st = STATUS_BAD;
                        end else begin
                            version_now = v;
                            fend = 1'b1;
                            cur_stage = STAGE_NL1;
                            tok_len = '0;
                        end
                    end else if (tok_len > VERSION_LEN_LIMIT) begin
                        st = STATUS_BAD;
                    end else begin
                        store_tok(c);
                        kind = KIND_VERSION;
                    end
                end
                STAGE_NL1, STAGE_NL2: begin
                    if (c == CH_LF) begin
                        cur_stage = STAGE_KEY;
                        field_seen = 1'b0;
                    end else begin
                        st = STATUS_BAD;
                    end
                end
                STAGE_KEY: begin
                    if (c == CH_CR) begin
                        if (field_seen) st = STATUS_BAD;
                        else cur_stage = STAGE_NL3;
                    end else if (c == CH_COLON) begin
                        fend = 1'b1;
                        cur_stage = STAGE_SPACE;
                        field_seen = 1'b0;
                    end else if (ctl_byte(c)) begin
                        st = STATUS_BAD;
                    end else begin
                        field_seen = 1'b1;
                        kind = KIND_KEY;
                    end
                end
                STAGE_SPACE: begin
                    if (c == CH_SP) cur_stage = STAGE_VALUE;
                    else st = STATUS_BAD;
                end
                STAGE_VALUE: begin
                    if (c == CH_CR) begin
                        fend = 1'b1;
                        cur_stage = STAGE_NL2;
                    end else if (ctl_byte(c)) begin
                        st = STATUS_BAD;
                    end else begin
                        kind = KIND_VALUE;
                    end
                end
                STAGE_NL3: begin
                    if (c == CH_LF) begin
                        hdone = 1'b1;
                        cur_stage = STAGE_PAYLOAD;
                    end else begin
                        st = STATUS_BAD;
                    end
                end
                STAGE_PAYLOAD: begin
                    if (method_now != METHOD_PUT && method_now != METHOD_POST &&
                        method_now != METHOD_PATCH) begin
                        st = STATUS_BAD;
                    end else if (body_bytes == '1 ||
                                 64'(body_bytes) + 64'd1 > 64'(body_limit)) begin
                        st = STATUS_TOO_LARGE;
                    end else begin
                        body_bytes = body_bytes + 1'b1;
                        kind = KIND_PAYLOAD;
                    end
                end
                default: st = STATUS_BAD;
            endcase
            if (st != STATUS_OK) begin
                sticky_err = 1'b1;
                kind = KIND_DELIM;
                fend = 1'b0;
                hdone = 1'b0;
            end
        end
        r.byte_out = c;
        r.byte_kind = kind;
        r.field_end = fend;
        r.head_done = hdone;
        r.status = st;
        r.method_code = method_now;
        r.version_code = version_now;
        return r;
    endfunction

    task automatic compare_field(input string name, input logic [7:0] exp_val,
                                 input logic [7:0] act_val);
        if (act_val !== exp_val) begin
            $display("%0t: %s expected %0d, got %0d", $time, name, exp_val, act_val);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_request();
            body_limit = MAX_BODY_RESET;
            predicted_tags.delete();
            fail_count = 0;
        end else begin
            if (cfg_we) body_limit = cfg_wdata;
            if (m_valid && m_ready) begin
                if (predicted_tags.size() == 0) begin
                    $display("%0t: result with no item pending, byte_out expected none, got %0d",
                             $time, m_byte_out);
                    fail_count++;
                end else begin
                    want = predicted_tags.pop_front();
                    compare_field("byte_out", want.byte_out, m_byte_out);
                    compare_field("byte_kind", want.byte_kind, m_byte_kind);
                    compare_field("field_end", want.field_end, m_field_end);
                    compare_field("head_done", want.head_done, m_head_done);
                    compare_field("status", want.status, m_status);
                    compare_field("method_code", want.method_code, m_method_code);
                    compare_field("version_code", want.version_code, m_version_code);
                end
            end
            if (s_valid && s_ready) begin
                want = tag_byte(s_data_byte, s_start_request);
                predicted_tags.push_back(want);
            end
        end
        pending = predicted_tags.size();
    end

endmodule

/* tb/sv/http_request_head_parser_unit_test.sv */
// top of the http request head parser test: clock, reset, request byte streams,
// body size settings and receiver stalls; depends on hpp_pkg and http_head_checker
module http_request_head_parser_unit_test;
    import hpp_pkg::*;

    localparam int STALL_LIMIT = 1000;
    localparam int ITEMS_PER_PHASE = 45;

    typedef enum {READY_OPEN, READY_RANDOM, READY_HELD} ready_mode_t;

    logic        aclk;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_data_byte = 8'd0;
    logic        s_start_request = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [7:0]  m_byte_out;
    logic [2:0]  m_byte_kind;
    logic        m_field_end;
    logic        m_head_done;
    logic [1:0]  m_status;
    logic [2:0]  m_method_code;
    logic [1:0]  m_version_code;
    logic        cfg_we = 1'b0;
    logic [31:0] cfg_wdata = 32'd0;

    int fail_count;
    int pending;
    int sent_count = 0;
    int stall_cycles = 0;
    int burst_left = 0;
    int ready_left = 0;
    ready_mode_t ready_mode = READY_OPEN;
    logic [7:0] req_q[$];
    logic [31:0] body_limits[$];

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    http_request_head_parser_unit u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data_byte     (s_data_byte),
        .s_start_request (s_start_request),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_byte_out      (m_byte_out),
        .m_byte_kind     (m_byte_kind),
        .m_field_end     (m_field_end),
        .m_head_done     (m_head_done),
        .m_status        (m_status),
        .m_method_code   (m_method_code),
        .m_version_code  (m_version_code),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata)
    );

    http_head_checker u_check (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data_byte     (s_data_byte),
        .s_start_request (s_start_request),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_byte_out      (m_byte_out),
        .m_byte_kind     (m_byte_kind),
        .m_field_end     (m_field_end),
        .m_head_done     (m_head_done),
        .m_status        (m_status),
        .m_method_code   (m_method_code),
        .m_version_code  (m_version_code),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .fail_count      (fail_count),
        .pending         (pending)
    );

    // receiver: open runs, coin-flip runs and held stalls
    always @(negedge aclk) begin
        if (ready_left == 0) begin
            case ($urandom_range(0, 3))
                0, 1: ready_mode = READY_OPEN;
                2: ready_mode = READY_RANDOM;
                default: ready_mode = READY_HELD;
            endcase
            ready_left = (ready_mode == READY_HELD) ? $urandom_range(1, 12)
                                                    : $urandom_range(1, 40);
        end
        ready_left--;
        case (ready_mode)
            READY_OPEN: m_ready <= 1'b1;
            READY_RANDOM: m_ready <= 1'($urandom_range(0, 1));
            default: m_ready <= 1'b0;
        endcase
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) stall_cycles <= 0;
        else stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("http_request_head_parser_unit_test: done, errors");
            $finish;
        end
    end

    task automatic push_byte(input logic [7:0] b, input logic restart);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 80)
                                                     : $urandom_range(1, 10);
            if (gap != 0) begin
                @(negedge aclk);
                s_valid <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
        end
        @(negedge aclk);
        s_valid <= 1'b1;
        s_data_byte <= b;
        s_start_request <= restart;
        burst_left--;
        do @(posedge aclk); while (!s_ready);
        sent_count++;
    endtask

    // drop valid and let every outstanding tag come back
    task automatic drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending != 0) @(negedge aclk);
    endtask

    task automatic set_body_limit(input logic [31:0] lim);
        drain();
        cfg_we <= 1'b1;
        cfg_wdata <= lim;
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    function automatic void add_text(input string s);
        for (int i = 0; i < s.len(); i++) req_q.push_back(s[i]);
    endfunction

    function automatic void add_crlf();
        req_q.push_back(CH_CR);
        req_q.push_back(CH_LF);
    endfunction

    function automatic string method_text(input int k);
        case (k)
            0: return "GET";
            1: return "PUT";
            2: return "POST";
            3: return "PATCH";
            4: return "DELETE";
            default: return "OPTIONS";
        endcase
    endfunction

    // printable or high byte, never a colon
    function automatic logic [7:0] name_byte();
        logic [7:0] b;
        if ($urandom_range(0, 7) == 0) b = 8'($urandom_range(128, 255));
        else b = 8'($urandom_range(33, 126));
        if (b == CH_COLON) b = "-";
        return b;
    endfunction

    function automatic void build_request();
        int pick;
        int n;
        req_q.delete();
        pick = $urandom_range(0, 11);
        if (pick < 6) begin
            add_text(method_text(pick));
        end else if (pick < 9) begin
            // favor methods that may carry a body
            add_text(method_text($urandom_range(1, 3)));
        end else if (pick == 9) begin
            n = $urandom_range(0, 10);
            repeat (n) req_q.push_back(name_byte());
        end else begin
            add_text(method_text($urandom_range(0, 5)));
            if (pick == 10) void'(req_q.pop_back());
            else req_q.push_back(name_byte());
        end
        req_q.push_back(CH_SP);
        if ($urandom_range(0, 11) != 0) req_q.push_back(CH_SLASH);
        n = $urandom_range(0, 6);
        repeat (n) req_q.push_back(name_byte());
        req_q.push_back(CH_SP);
        case ($urandom_range(0, 11))
            0: add_text("HTTP/1");
            1: add_text("HTTP/1.11");
            2: add_text("HTTP/1.100");
            3: begin
                add_text("HTTP/1.");
                req_q.push_back(name_byte());
            end
            4, 5, 6: add_text("HTTP/1.0");
            default: add_text("HTTP/1.1");
        endcase
        add_crlf();
        repeat ($urandom_range(0, 3)) begin
            n = $urandom_range(0, 5);
            repeat (n) req_q.push_back(name_byte());
            add_text(": ");
            n = $urandom_range(0, 6);
            repeat (n) req_q.push_back(($urandom_range(0, 9) == 0) ? CH_SP : name_byte());
            add_crlf();
        end
        add_crlf();
        n = $urandom_range(0, 8);
        repeat (n) req_q.push_back(8'($urandom_range(0, 255)));
        // occasional corrupt byte anywhere in the request
        if ($urandom_range(0, 4) == 0)
            req_q[$urandom_range(0, req_q.size() - 1)] = 8'($urandom_range(0, 255));
    endfunction

    task automatic send_request();
        int restart_at;
        logic first_start;
        first_start = ($urandom_range(0, 11) != 0);
        restart_at = ($urandom_range(0, 9) == 0) ? $urandom_range(1, req_q.size() - 1) : -1;
        for (int i = 0; i < req_q.size(); i++)
            push_byte(req_q[i], (i == 0) ? first_start : (i == restart_at));
    endtask

    task automatic send_fixed(input string s);
        req_q.delete();
        add_text(s);
        for (int i = 0; i < req_q.size(); i++) push_byte(req_q[i], i == 0);
    endtask

    initial begin
        int target;
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;

        // full post with a header and extreme payload bytes
        send_fixed("POST /a HTTP/1.1\015\012k: v\015\012\015\012");
        push_byte(8'h00, 1'b0);
        push_byte(8'hff, 1'b0);
        // ninth method byte, then a dropped byte
        send_fixed("OPTIONSXYZ");
        // uri without leading slash, and an empty uri
        send_fixed("GET x ");
        send_fixed("GET  ");
        // control byte in the uri
        send_fixed("DELETE /\001");
        // tenth version byte
        send_fixed("PATCH / HTTP/1.100");
        // version 1.0, blank line, then a body byte on a get
        send_fixed("GET / HTTP/1.0\015\012\015\012z");
        // line end after key bytes
        send_fixed("PUT / HTTP/1.1\015\012ab\015");

        body_limits = '{32'd0, 32'd1, 32'd3, 32'hffff_ffff, 32'($urandom_range(2, 10)),
                        $urandom(), 32'd7, MAX_BODY_RESET};
        foreach (body_limits[p]) begin
            set_body_limit(body_limits[p]);
            target = sent_count + ITEMS_PER_PHASE;
            while (sent_count < target) begin
                build_request();
                send_request();
            end
        end

        drain();
        repeat (4) @(negedge aclk);
        if (fail_count == 0 && pending == 0)
            $display("http_request_head_parser_unit_test: done, clean");
        else
            $display("http_request_head_parser_unit_test: done, errors");
        $finish;
    end

endmodule
